[sv/echo_suppress_line_composer_macros.svh]
// assertion helpers used by the datapath
`ifndef ECHO_SUPPRESS_LINE_COMPOSER_MACROS_SVH
`define ECHO_SUPPRESS_LINE_COMPOSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ESLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ESLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/eslc_pkg.sv]
`default_nettype none
package eslc_pkg;

    localparam int MAX_COMMAND_LENGTH = 62;
    localparam int STORE_DEPTH        = MAX_COMMAND_LENGTH + 1;
    localparam int ADDR_W             = $clog2(STORE_DEPTH);

    localparam logic [7:0] LINE_FEED = 8'h0A;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ARM   = 2'd1,
        CMD_RECV  = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RPL_RD,
        ST_RPL_PUSH,
        ST_TAIL
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec_fire;
        logic rpl_read;
        logic rpl_push;
        logic tail_push;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic exec_push;
        logic exec_replay;
        logic has_prefix;
        logic rpl_last;
    } dp_status_t;

endpackage
`default_nettype wire

[sv/eslc_ctrl.sv]
`default_nettype none
module eslc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire eslc_pkg::dp_status_t status,
    output eslc_pkg::ctrl_cmd_t     cmd
);
    import eslc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!status.exec_push) begin
                    cmd.exec_fire = 1'b1;
                    state_next    = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.exec_fire = 1'b1;
                    if (!status.exec_replay) begin
                        state_next = ST_IDLE;
                    end else if (status.has_prefix) begin
                        state_next = ST_RPL_RD;
                    end else begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_RPL_RD: begin
                cmd.rpl_read = 1'b1;
                state_next   = ST_RPL_PUSH;
            end
            ST_RPL_PUSH: begin
                if (status.out_free) begin
                    cmd.rpl_push = 1'b1;
                    state_next   = status.rpl_last ? ST_TAIL : ST_RPL_RD;
                end
            end
            ST_TAIL: begin
                if (status.out_free) begin
                    cmd.tail_push = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/eslc_datapath.sv]
`default_nettype none
module eslc_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [1:0]         s_command,
    input  wire logic [7:0]         s_data_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_out_byte,
    output logic                    m_is_last,
    output logic                    m_composer_active,
    output logic                    m_overflow_flag,
    input  wire eslc_pkg::ctrl_cmd_t cmd,
    output eslc_pkg::dp_status_t    status
);
    import eslc_pkg::*;
    `include "echo_suppress_line_composer_macros.svh"

    // template memory, no reset: read data is used only below the fill length
    logic [7:0] tmpl_mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;
    addr_t      rd_addr;
    logic       rd_en;

    // captured word
    cmd_t       cmd_reg;
    logic [7:0] byte_reg;

    // composer state
    addr_t len_reg,     len_next;
    addr_t matched_reg, matched_next;
    logic  armed_reg,   armed_next;
    logic  owed_reg,    owed_next;
    logic  ovf_reg,     ovf_next;
    addr_t idx_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_active_reg;
    logic       out_ovf_reg;

    logic       wr_en;
    logic [7:0] wr_data;
    logic       exec_push;
    logic       exec_replay;
    logic [7:0] push_byte;
    logic       push_last;
    logic       push;
    logic [7:0] sel_byte;
    logic       sel_last;
    logic       sel_active;
    logic       sel_ovf;
    addr_t      matched_inc;

    assign matched_inc = matched_reg + addr_t'(1);

    // decide what the captured word does
    always_comb begin
        armed_next   = armed_reg;
        len_next     = len_reg;
        matched_next = matched_reg;
        owed_next    = owed_reg;
        ovf_next     = ovf_reg;
        wr_en        = 1'b0;
        wr_data      = byte_reg;
        exec_push    = 1'b0;
        exec_replay  = 1'b0;
        push_byte    = byte_reg;
        push_last    = 1'b1;
        case (cmd_reg)
            CMD_LOAD: begin
                if (!armed_reg) begin
                    exec_push = 1'b1;
                    if (len_reg < addr_t'(MAX_COMMAND_LENGTH)) begin
                        wr_en    = 1'b1;
                        len_next = len_reg + addr_t'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            CMD_ARM: begin
                if (!armed_reg) begin
                    if (ovf_reg) begin
                        ovf_next = 1'b0;
                        len_next = '0;
                    end else begin
                        wr_en        = 1'b1;
                        wr_data      = LINE_FEED;
                        len_next     = len_reg + addr_t'(1);
                        matched_next = '0;
                        owed_next    = 1'b1;
                        armed_next   = 1'b1;
                    end
                end
            end
            CMD_RECV: begin
                if (!armed_reg) begin
                    exec_push = 1'b1;
                end else if (byte_reg == rd_data_reg) begin
                    matched_next = matched_inc;
                    if (matched_inc >= len_reg) begin
                        exec_push    = owed_reg;
                        push_byte    = LINE_FEED;
                        len_next     = '0;
                        matched_next = '0;
                        owed_next    = 1'b0;
                        armed_next   = 1'b0;
                    end
                end else begin
                    exec_push  = 1'b1;
                    len_next   = '0;
                    owed_next  = 1'b0;
                    armed_next = 1'b0;
                    if (matched_reg == '0 && byte_reg == LINE_FEED) begin
                        matched_next = '0;
                    end else begin
                        // replay keeps the matched count as its limit
                        push_byte   = LINE_FEED;
                        push_last   = 1'b0;
                        exec_replay = 1'b1;
                    end
                end
            end
            CMD_FLUSH: begin
                if (armed_reg) begin
                    exec_push    = owed_reg;
                    push_byte    = LINE_FEED;
                    len_next     = '0;
                    matched_next = '0;
                    owed_next    = 1'b0;
                    armed_next   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign rd_en   = cmd.capture | cmd.rpl_read;
    assign rd_addr = cmd.capture ? matched_reg : idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec_fire && wr_en) begin
            tmpl_mem[len_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= tmpl_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg  <= cmd_t'(s_command);
            byte_reg <= s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            matched_reg <= '0;
            armed_reg   <= 1'b0;
            owed_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (cmd.exec_fire) begin
                len_reg     <= len_next;
                matched_reg <= matched_next;
                armed_reg   <= armed_next;
                owed_reg    <= owed_next;
                ovf_reg     <= ovf_next;
                idx_reg     <= '0;
            end
            if (cmd.rpl_push) begin
                idx_reg <= idx_reg + addr_t'(1);
            end
            if (cmd.tail_push) begin
                matched_reg <= '0;
            end
        end
    end

    // output register source select
    assign push = (cmd.exec_fire & exec_push) | cmd.rpl_push | cmd.tail_push;

    always_comb begin
        sel_byte   = byte_reg;
        sel_last   = 1'b1;
        sel_active = armed_reg;
        sel_ovf    = ovf_reg;
        if (cmd.exec_fire) begin
            sel_byte   = push_byte;
            sel_last   = push_last;
            sel_active = armed_next;
            sel_ovf    = ovf_next;
        end else if (cmd.rpl_push) begin
            sel_byte = rd_data_reg;
            sel_last = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_byte_reg   <= sel_byte;
            out_last_reg   <= sel_last;
            out_active_reg <= sel_active;
            out_ovf_reg    <= sel_ovf;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_out_byte        = out_byte_reg;
    assign m_is_last         = out_last_reg;
    assign m_composer_active = out_active_reg;
    assign m_overflow_flag   = out_ovf_reg;

    assign status.out_free    = !out_valid_reg || m_ready;
    assign status.exec_push   = exec_push;
    assign status.exec_replay = exec_replay;
    assign status.has_prefix  = matched_reg != '0;
    assign status.rpl_last    = (idx_reg + addr_t'(1)) == matched_reg;

    `ESLC_ASSERT_NOW(a_push_into_free, push, (!out_valid_reg || m_ready),
        "result pushed over a word still waiting")
    `ESLC_ASSERT_NOW(a_armed_bounds, armed_reg, (len_reg != '0 && matched_reg < len_reg),
        "armed with empty template or match count past template")
    `ESLC_ASSERT_NOW(a_owed_tracks_armed, 1'b1, (owed_reg == armed_reg),
        "line feed owed flag out of step with armed flag")
    `ESLC_ASSERT_NOW(a_replay_in_prefix, cmd.rpl_read, (idx_reg < matched_reg && !armed_reg),
        "replay read outside the matched prefix")

endmodule
`default_nettype wire

[sv/echo_suppress_line_composer.sv]
// echo suppressor for a locally typed command line. each input word carries a
// command (load byte, arm, received byte, flush) and a data byte; each result
// word carries one byte for the terminal stream with is_last on the final byte
// caused by that input word, plus the armed and overload flags after the word.
// loads store the byte in a 63-entry template and echo it; past 62 bytes the
// byte is still echoed but the overload flag is set, and the next arm then only
// clears the template. arm appends a line feed and starts matching received
// bytes against the template, one template read per received byte. a full
// match gives a single line feed; a divergence gives back a line feed, the
// matched prefix and the odd byte (a lone leading line feed just passes).
// timing: the block takes a word in idle and works it in the execute state, which
// waits while the result side is full if the word pushes, and is ready again only
// back in idle. the result sits in an output register, so a new word is taken while
// the last result still waits. a divergence replay reads and then pushes each
// matched template byte (one template memory read, one push), then pushes the
// trailing byte; any stall on m_ready stretches these states.
`default_nettype none
module echo_suppress_line_composer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input words
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_command,
    input  wire logic [7:0] s_data_byte,
    // result words
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_is_last,
    output logic            m_composer_active,
    output logic            m_overflow_flag
);
    import eslc_pkg::*;

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: idle, execute, replay read/push, trailing byte
    eslc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // template memory, match state and output register
    eslc_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_command         (s_command),
        .s_data_byte       (s_data_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_is_last         (m_is_last),
        .m_composer_active (m_composer_active),
        .m_overflow_flag   (m_overflow_flag),
        .cmd               (cmd),
        .status            (status)
    );

endmodule
`default_nettype wire
